FILE: rtl/core/skt_pkg.sv
package skt_pkg;

  localparam int MAX_KNOTS = 16;
  localparam int IDX_W     = $clog2(MAX_KNOTS);
  localparam int CNT_W     = $clog2(MAX_KNOTS + 1);
  localparam int VAL_W     = 32;
  localparam int OP_W      = 3;
  localparam int ST_W      = 3;

  typedef enum logic [OP_W-1:0] {
    OP_ADD        = 3'd0,
    OP_REMOVE_X   = 3'd1,
    OP_REMOVE_IDX = 3'd2,
    OP_MOVE_IDX   = 3'd3,
    OP_MOVE_X     = 3'd4,
    OP_FIND       = 3'd5,
    OP_READ       = 3'd6
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 3'd0,
    ST_DUP     = 3'd1,
    ST_INDEX   = 3'd2,
    ST_MISSING = 3'd3,
    ST_FULL    = 3'd4
  } status_e;

  typedef struct packed {
    logic             load;
    logic             srch;
    logic             rem_en;
    logic             ins_en;
    logic             wy_en;
    logic             rd_en;
    logic [IDX_W-1:0] rem_idx;
    logic [IDX_W-1:0] ins_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] lk;
    logic             ek;
    logic [CNT_W-1:0] ln;
    logic             en;
    logic [CNT_W-1:0] cnt;
  } dp_sts_t;

endpackage

FILE: rtl/core/sorted_knot_table.sv
// Channel   Handshake                  Payload
// input     in_valid_i / in_ready_o    op_i key_x_i new_x_i new_y_i position_i replace_i
// output    out_valid_o / out_ready_i  status_o position_out_o knot_count_o read_x_o read_y_o
//
// Each transfer goes through capture, parallel search of all knots, decision,
// remove shift, insert shift and result, in that order. Each shift moves the whole
// table in parallel. One item at a time; a new input is taken once the result
// has been transferred. Reset empties the table; knot storage has no reset.
module sorted_knot_table
  import skt_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [OP_W-1:0]         op_i,
  input  logic signed [VAL_W-1:0] key_x_i,
  input  logic signed [VAL_W-1:0] new_x_i,
  input  logic signed [VAL_W-1:0] new_y_i,
  input  logic [IDX_W-1:0]        position_i,
  input  logic                    replace_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [ST_W-1:0]         status_o,
  output logic [IDX_W-1:0]        position_out_o,
  output logic [CNT_W-1:0]        knot_count_o,
  output logic signed [VAL_W-1:0] read_x_o,
  output logic signed [VAL_W-1:0] read_y_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  skt_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .op_i,
    .position_i,
    .replace_i,
    .out_valid_o,
    .out_ready_i,
    .status_o,
    .position_out_o,
    .cmd_o (cmd),
    .sts_i (sts)
  );

  skt_dp u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i        (cmd),
    .key_x_i,
    .new_x_i,
    .new_y_i,
    .sts_o        (sts),
    .knot_count_o,
    .read_x_o,
    .read_y_o
  );

endmodule

FILE: rtl/core/skt_dp.sv
module skt_dp
  import skt_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dp_cmd_t                 cmd_i,
  input  logic signed [VAL_W-1:0] key_x_i,
  input  logic signed [VAL_W-1:0] new_x_i,
  input  logic signed [VAL_W-1:0] new_y_i,
  output dp_sts_t                 sts_o,
  output logic [CNT_W-1:0]        knot_count_o,
  output logic signed [VAL_W-1:0] read_x_o,
  output logic signed [VAL_W-1:0] read_y_o
);

  logic signed [VAL_W-1:0] xs_q [MAX_KNOTS];
  logic signed [VAL_W-1:0] ys_q [MAX_KNOTS];
  logic [CNT_W-1:0]        count_q;
  logic signed [VAL_W-1:0] key_q, nx_q, ny_q, rx_q, ry_q;
  dp_sts_t                 sts_q, sts_d;

  always_comb begin
    logic hk, hn;
    hk = 1'b0;
    hn = 1'b0;
    sts_d     = '0;
    sts_d.lk  = CNT_W'(MAX_KNOTS);
    sts_d.ln  = CNT_W'(MAX_KNOTS);
    sts_d.cnt = count_q;
    for (int j = 0; j < MAX_KNOTS; j++) begin
      if (!hk && (CNT_W'(j) >= count_q || !(xs_q[j] < key_q))) begin
        sts_d.lk = CNT_W'(j);
        hk = 1'b1;
      end
      if (!hn && (CNT_W'(j) >= count_q || !(xs_q[j] < nx_q))) begin
        sts_d.ln = CNT_W'(j);
        hn = 1'b1;
      end
      if (CNT_W'(j) < count_q && xs_q[j] == key_q) sts_d.ek = 1'b1;
      if (CNT_W'(j) < count_q && xs_q[j] == nx_q) sts_d.en = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q <= key_x_i;
      nx_q  <= new_x_i;
      ny_q  <= new_y_i;
    end
    if (cmd_i.srch) sts_q <= sts_d;
    if (cmd_i.load) begin
      rx_q <= '0;
      ry_q <= '0;
    end else if (cmd_i.rd_en) begin
      rx_q <= xs_q[cmd_i.rem_idx];
      ry_q <= ys_q[cmd_i.rem_idx];
    end
    if (cmd_i.rem_en) begin
      for (int j = 0; j < MAX_KNOTS - 1; j++) begin
        if (IDX_W'(j) >= cmd_i.rem_idx) begin
          xs_q[j] <= xs_q[j+1];
          ys_q[j] <= ys_q[j+1];
        end
      end
    end
    if (cmd_i.ins_en) begin
      for (int j = 1; j < MAX_KNOTS; j++) begin
        if (IDX_W'(j) > cmd_i.ins_idx) begin
          xs_q[j] <= xs_q[j-1];
          ys_q[j] <= ys_q[j-1];
        end
      end
      xs_q[cmd_i.ins_idx] <= nx_q;
      ys_q[cmd_i.ins_idx] <= ny_q;
    end
    if (cmd_i.wy_en) ys_q[cmd_i.ins_idx] <= ny_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.rem_en && !cmd_i.ins_en) begin
      count_q <= count_q - CNT_W'(1);
    end else if (cmd_i.ins_en && !cmd_i.rem_en) begin
      count_q <= count_q + CNT_W'(1);
    end
  end

  assign sts_o        = sts_q;
  assign knot_count_o = count_q;
  assign read_x_o     = rx_q;
  assign read_y_o     = ry_q;

endmodule

FILE: rtl/core/skt_ctrl.sv
module skt_ctrl
  import skt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [OP_W-1:0]   op_i,
  input  logic [IDX_W-1:0]  position_i,
  input  logic              replace_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ST_W-1:0]   status_o,
  output logic [IDX_W-1:0]  position_out_o,
  output dp_cmd_t           cmd_o,
  input  dp_sts_t           sts_i
);

  typedef enum logic [2:0] {
    S_IDLE, S_SRCH, S_DECIDE, S_ACT1, S_ACT2, S_DONE
  } state_e;

  state_e           state_q;
  op_e              op_q;
  logic [IDX_W-1:0] pos_q, where_q, rem_idx_q, ins_idx_q;
  logic             rep_q, rem_q, ins_q, wy_q, rd_q;
  status_e          st_q;

  status_e          st_d;
  logic [IDX_W-1:0] where_d, rem_idx_d, ins_idx_d;
  logic             rem_d, ins_d, wy_d, rd_d;

  always_comb begin
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] ins, a, lim;
    logic             bad;
    st_d      = ST_OK;
    where_d   = '0;
    rem_idx_d = '0;
    ins_idx_d = '0;
    rem_d     = 1'b0;
    ins_d     = 1'b0;
    wy_d      = 1'b0;
    rd_d      = 1'b0;
    idx = (op_q == OP_MOVE_IDX) ? pos_q : sts_i.lk[IDX_W-1:0];
    bad = (op_q == OP_MOVE_IDX) ? ({1'b0, pos_q} >= sts_i.cnt) : !sts_i.ek;
    ins = sts_i.ln - (({1'b0, idx} < sts_i.ln) ? CNT_W'(1) : CNT_W'(0));
    a   = (sts_i.lk == '0) ? '0 : sts_i.lk - CNT_W'(1);
    lim = sts_i.cnt - CNT_W'(2);
    unique case (op_q)
      OP_ADD: begin
        if (sts_i.en) begin
          if (rep_q) begin
            wy_d      = 1'b1;
            ins_idx_d = sts_i.ln[IDX_W-1:0];
            where_d   = sts_i.ln[IDX_W-1:0];
          end else begin
            st_d = ST_DUP;
          end
        end else if (sts_i.cnt == CNT_W'(MAX_KNOTS)) begin
          st_d = ST_FULL;
        end else begin
          ins_d     = 1'b1;
          ins_idx_d = sts_i.ln[IDX_W-1:0];
          where_d   = sts_i.ln[IDX_W-1:0];
        end
      end
      OP_REMOVE_X: begin
        if (!sts_i.ek) begin
          st_d = ST_MISSING;
        end else begin
          rem_d     = 1'b1;
          rem_idx_d = sts_i.lk[IDX_W-1:0];
          where_d   = sts_i.lk[IDX_W-1:0];
        end
      end
      OP_REMOVE_IDX: begin
        if ({1'b0, pos_q} >= sts_i.cnt) begin
          st_d = ST_INDEX;
        end else begin
          rem_d     = 1'b1;
          rem_idx_d = pos_q;
          where_d   = pos_q;
        end
      end
      OP_MOVE_IDX, OP_MOVE_X: begin
        if (bad) begin
          st_d = (op_q == OP_MOVE_IDX) ? ST_INDEX : ST_MISSING;
        end else if (sts_i.en && sts_i.ln != {1'b0, idx}) begin
          st_d = ST_DUP;
        end else begin
          rem_d     = 1'b1;
          ins_d     = 1'b1;
          rem_idx_d = idx;
          ins_idx_d = ins[IDX_W-1:0];
          where_d   = ins[IDX_W-1:0];
        end
      end
      OP_FIND: begin
        if (sts_i.cnt >= CNT_W'(2)) where_d = (a > lim) ? lim[IDX_W-1:0] : a[IDX_W-1:0];
      end
      OP_READ: begin
        if ({1'b0, pos_q} >= sts_i.cnt) begin
          st_d = ST_INDEX;
        end else begin
          rd_d      = 1'b1;
          rem_idx_d = pos_q;
          where_d   = pos_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      op_q      <= OP_ADD;
      pos_q     <= '0;
      rep_q     <= 1'b0;
      st_q      <= ST_OK;
      where_q   <= '0;
      rem_idx_q <= '0;
      ins_idx_q <= '0;
      rem_q     <= 1'b0;
      ins_q     <= 1'b0;
      wy_q      <= 1'b0;
      rd_q      <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            op_q    <= op_e'(op_i);
            pos_q   <= position_i;
            rep_q   <= replace_i;
            state_q <= S_SRCH;
          end
        end
        S_SRCH: state_q <= S_DECIDE;
        S_DECIDE: begin
          st_q      <= st_d;
          where_q   <= where_d;
          rem_idx_q <= rem_idx_d;
          ins_idx_q <= ins_idx_d;
          rem_q     <= rem_d;
          ins_q     <= ins_d;
          wy_q      <= wy_d;
          rd_q      <= rd_d;
          state_q   <= S_ACT1;
        end
        S_ACT1: state_q <= S_ACT2;
        S_ACT2: state_q <= S_DONE;
        S_DONE: begin
          if (out_ready_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.load    = (state_q == S_IDLE) && in_valid_i;
    cmd_o.srch    = (state_q == S_SRCH);
    cmd_o.rem_en  = (state_q == S_ACT1) && rem_q;
    cmd_o.wy_en   = (state_q == S_ACT1) && wy_q;
    cmd_o.rd_en   = (state_q == S_ACT1) && rd_q;
    cmd_o.ins_en  = (state_q == S_ACT2) && ins_q;
    cmd_o.rem_idx = rem_idx_q;
    cmd_o.ins_idx = ins_idx_q;
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = (state_q == S_DONE);
  assign status_o       = st_q;
  assign position_out_o = where_q;

`ifndef NO_ASSERTIONS
  a_one_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.rem_en && cmd_o.ins_en))
    else $error("remove and insert in one cycle");
  a_fail_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && st_q != ST_OK |-> where_q == '0)
    else $error("failed op reports a position");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o && !out_valid_o)
    else $error("accepted transfer not held");
  a_fail_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ACT1 && st_q != ST_OK |-> !rem_q && !ins_q && !wy_q && !rd_q)
    else $error("failed op changes the table");
`endif

endmodule
